[rtl/core/alm_pkg.sv]
// Shared types, constants and the decibel threshold table for the audio level meter.
// Used by alm_ctrl, alm_datapath and audio_level_meter_db; depends on nothing.
package alm_pkg;

   // Field and register widths
   localparam int SampleWidth = 16;
   localparam int SumWidth    = 32;
   localparam int CountWidth  = 16;
   localparam int WinWidth    = 10;
   localparam int LevelWidth  = 6;
   localparam int ThrWidth    = 20;
   localparam int DivCntWidth = 5;
   localparam int BitIdxWidth = 3;
   localparam int CsrAddrWidth = 4;

   localparam logic [SampleWidth-1:0] SignFold   = 16'h8000;
   localparam logic [SampleWidth-1:0] FoldBase   = 16'hffff;
   localparam logic [LevelWidth-1:0]  LevelMax   = 6'd60;
   localparam logic [WinWidth-1:0]    WinSat     = 10'h3ff;
   localparam logic [DivCntWidth-1:0] DivLast    = 5'd31;
   localparam logic [BitIdxWidth-1:0] BitTop     = 3'd5;

   // Reset values of the configuration registers
   localparam logic [CountWidth-1:0] WindowSamplesRst = 16'd64;
   localparam logic [CountWidth-1:0] LevelOffsetRst   = 16'd270;
   localparam logic [WinWidth-1:0]   WindowLimitRst   = 10'd399;

   // Register byte addresses
   localparam logic [CsrAddrWidth-1:0] AddrWindowSamples = 4'h0;
   localparam logic [CsrAddrWidth-1:0] AddrLevelOffset   = 4'h4;
   localparam logic [CsrAddrWidth-1:0] AddrWindowLimit   = 4'h8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_PREP,
      ST_LEVEL,
      ST_SEND
   } st_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic div_step;
      logic lvl_init;
      logic lvl_step;
      logic out_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic closing;
      logic past;
      logic div_last;
      logic lvl_last;
      logic out_full;
   } sts_type;

   // Smallest integer not below 10^(L/10), L = 0..60
   function automatic logic [ThrWidth-1:0] db_threshold(input logic [LevelWidth-1:0] idx);
      logic [ThrWidth-1:0] t;
      case (idx)
         6'd0:  t = 20'd1;      6'd1:  t = 20'd2;      6'd2:  t = 20'd2;
         6'd3:  t = 20'd2;      6'd4:  t = 20'd3;      6'd5:  t = 20'd4;
         6'd6:  t = 20'd4;      6'd7:  t = 20'd6;      6'd8:  t = 20'd7;
         6'd9:  t = 20'd8;      6'd10: t = 20'd10;     6'd11: t = 20'd13;
         6'd12: t = 20'd16;     6'd13: t = 20'd20;     6'd14: t = 20'd26;
         6'd15: t = 20'd32;     6'd16: t = 20'd40;     6'd17: t = 20'd51;
         6'd18: t = 20'd64;     6'd19: t = 20'd80;     6'd20: t = 20'd100;
         6'd21: t = 20'd126;    6'd22: t = 20'd159;    6'd23: t = 20'd200;
         6'd24: t = 20'd252;    6'd25: t = 20'd317;    6'd26: t = 20'd399;
         6'd27: t = 20'd502;    6'd28: t = 20'd631;    6'd29: t = 20'd795;
         6'd30: t = 20'd1000;   6'd31: t = 20'd1259;   6'd32: t = 20'd1585;
         6'd33: t = 20'd1996;   6'd34: t = 20'd2512;   6'd35: t = 20'd3163;
         6'd36: t = 20'd3982;   6'd37: t = 20'd5012;   6'd38: t = 20'd6310;
         6'd39: t = 20'd7944;   6'd40: t = 20'd10000;  6'd41: t = 20'd12590;
         6'd42: t = 20'd15849;  6'd43: t = 20'd19953;  6'd44: t = 20'd25119;
         6'd45: t = 20'd31623;  6'd46: t = 20'd39811;  6'd47: t = 20'd50119;
         6'd48: t = 20'd63096;  6'd49: t = 20'd79433;  6'd50: t = 20'd100000;
         6'd51: t = 20'd125893; 6'd52: t = 20'd158490; 6'd53: t = 20'd199527;
         6'd54: t = 20'd251189; 6'd55: t = 20'd316228; 6'd56: t = 20'd398108;
         6'd57: t = 20'd501188; 6'd58: t = 20'd630958; 6'd59: t = 20'd794329;
         6'd60: t = 20'd1000000;
         default: t = 20'hfffff;
      endcase
      return t;
   endfunction

endpackage

[rtl/core/alm_ctrl.sv]
// Sequencer for the audio level meter: accept, divide, level search, send.
// Depends on alm_pkg; drives alm_datapath through cmd_type, reads sts_type.
module alm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             rsp_tready,
   input  alm_pkg::sts_type sts,
   output alm_pkg::cmd_type cmd
);

   alm_pkg::st_type state_ff;
   alm_pkg::st_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= alm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         alm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (sts.closing) begin
                  state_in = sts.past ? alm_pkg::ST_SEND : alm_pkg::ST_DIV;
               end
            end
         end
         alm_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = alm_pkg::ST_PREP;
            end
         end
         alm_pkg::ST_PREP: begin
            cmd.lvl_init = 1'b1;
            state_in     = alm_pkg::ST_LEVEL;
         end
         alm_pkg::ST_LEVEL: begin
            cmd.lvl_step = 1'b1;
            if (sts.lvl_last) begin
               state_in = alm_pkg::ST_SEND;
            end
         end
         alm_pkg::ST_SEND: begin
            if (!sts.out_full || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = alm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = alm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/core/alm_datapath.sv]
// Datapath of the audio level meter: magnitude accumulator, window counters,
// radix-2 divider, bitwise level search and the result register. Depends on alm_pkg.
module alm_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  alm_pkg::cmd_type                     cmd,
   output alm_pkg::sts_type                     sts,
   input  logic [alm_pkg::SampleWidth-1:0]      sample,
   input  logic                                 restart,
   input  logic [alm_pkg::CountWidth-1:0]       window_samples,
   input  logic [alm_pkg::CountWidth-1:0]       level_offset,
   input  logic [alm_pkg::WinWidth-1:0]         window_limit,
   input  logic                                 rsp_tready,
   output logic                                 rsp_valid,
   output logic [alm_pkg::LevelWidth-1:0]       rsp_level,
   output logic                                 rsp_past
);

   logic [alm_pkg::SumWidth-1:0]    sum_ff, sum_in;
   logic [alm_pkg::CountWidth-1:0]  cnt_ff, cnt_in;
   logic [alm_pkg::WinWidth-1:0]    win_ff, win_in;
   logic [alm_pkg::SumWidth-1:0]    quo_ff;
   logic [alm_pkg::CountWidth-1:0]  rem_ff;
   logic [alm_pkg::CountWidth-1:0]  dsr_ff;
   logic [alm_pkg::DivCntWidth-1:0] dcnt_ff;
   logic [alm_pkg::SumWidth-1:0]    x_ff;
   logic [alm_pkg::LevelWidth-1:0]  lvl_ff;
   logic [alm_pkg::BitIdxWidth-1:0] bit_ff;
   logic                            past_ff;
   logic                            ovalid_ff;
   logic [alm_pkg::LevelWidth-1:0]  olvl_ff;
   logic                            opast_ff;

   logic [alm_pkg::SampleWidth-1:0] mag;
   logic [alm_pkg::SumWidth-1:0]    sum_base, sum_new;
   logic [alm_pkg::CountWidth-1:0]  cnt_next, size;
   logic [alm_pkg::WinWidth-1:0]    win_base;
   logic                            closing, past;
   logic [alm_pkg::CountWidth:0]    rem_sh;
   logic                            ge;
   logic [alm_pkg::CountWidth:0]    rem_sub;
   logic                            pos;
   logic [alm_pkg::LevelWidth-1:0]  cand;
   logic                            take;

   // Fold sample to magnitude and find out whether this request closes a window
   always_comb begin
      mag      = (sample >= alm_pkg::SignFold) ? (alm_pkg::FoldBase - sample) : sample;
      sum_base = restart ? '0 : sum_ff;
      sum_new  = sum_base + {{(alm_pkg::SumWidth-alm_pkg::SampleWidth){1'b0}}, mag};
      cnt_next = restart ? alm_pkg::CountWidth'(1) : cnt_ff + alm_pkg::CountWidth'(1);
      size     = (window_samples == '0) ? alm_pkg::CountWidth'(1) : window_samples;
      closing  = (cnt_next == '0) || (cnt_next >= size);
      win_base = restart ? '0 : win_ff;
      past     = (win_base >= window_limit);
   end

   // Accumulator and counters
   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      win_in = win_ff;
      if (cmd.accept) begin
         sum_in = closing ? '0 : sum_new;
         cnt_in = closing ? '0 : cnt_next;
         win_in = win_base;
         if (closing && !past && (win_base != alm_pkg::WinSat)) begin
            win_in = win_base + alm_pkg::WinWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
         win_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         win_ff <= win_in;
      end
   end

   // Restoring divider step, one quotient bit per cycle
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[alm_pkg::SumWidth-1]};
      ge      = (rem_sh >= {1'b0, dsr_ff});
      rem_sub = rem_sh - {1'b0, dsr_ff};
   end

   // Level search step: try setting one more bit of the level
   always_comb begin
      pos  = (quo_ff > {{(alm_pkg::SumWidth-alm_pkg::CountWidth){1'b0}}, level_offset});
      cand = lvl_ff | (alm_pkg::LevelWidth'(1) << bit_ff);
      take = (cand <= alm_pkg::LevelMax) &&
             ({{(alm_pkg::SumWidth-alm_pkg::ThrWidth){1'b0}}, alm_pkg::db_threshold(cand)}
              <= x_ff);
   end

   // Divider and level search registers (payload, no reset)
   always_ff @(posedge clock) begin
      if (cmd.accept && closing) begin
         quo_ff  <= sum_new;
         rem_ff  <= '0;
         dsr_ff  <= size;
         dcnt_ff <= '0;
         lvl_ff  <= '0;
         past_ff <= past;
      end else if (cmd.div_step) begin
         quo_ff  <= {quo_ff[alm_pkg::SumWidth-2:0], ge};
         rem_ff  <= ge ? rem_sub[alm_pkg::CountWidth-1:0] : rem_sh[alm_pkg::CountWidth-1:0];
         dcnt_ff <= dcnt_ff + alm_pkg::DivCntWidth'(1);
      end else if (cmd.lvl_init) begin
         x_ff   <= pos ? (quo_ff - {{(alm_pkg::SumWidth-alm_pkg::CountWidth){1'b0}},
                                    level_offset} + alm_pkg::SumWidth'(1)) : '0;
         lvl_ff <= '0;
         bit_ff <= alm_pkg::BitTop;
      end else if (cmd.lvl_step) begin
         if (take) begin
            lvl_ff <= cand;
         end
         bit_ff <= bit_ff - alm_pkg::BitIdxWidth'(1);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         ovalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         olvl_ff  <= lvl_ff;
         opast_ff <= past_ff;
      end
   end

   always_comb begin
      sts.closing  = closing;
      sts.past     = past;
      sts.div_last = (dcnt_ff == alm_pkg::DivLast);
      sts.lvl_last = (bit_ff == '0);
      sts.out_full = ovalid_ff;
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_level = olvl_ff;
   assign rsp_past  = opast_ff;

endmodule

[rtl/core/audio_level_meter_db.sv]
// Audio level meter top level: APB-style register file, controller and datapath.
// Depends on alm_pkg, alm_ctrl and alm_datapath.
// Requests that do not close a window can follow back to back. A window-closing request
// runs accept, 32 divider steps, 1 setup, 6 level-search steps and 1 result load (past the
// limit: accept and load only); the load waits on a still-unaccepted result.
// Synchronous active-high reset clears the counts, the result valid and loads register defaults.
module audio_level_meter_db (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,   // [15:0] sample
   input  logic [0:0]                        req_tuser,   // [0] restart
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [5:0] level_db, [7:6] zero
   output logic [0:0]                        rsp_tuser,   // [0] past_limit
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [alm_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   logic [alm_pkg::CountWidth-1:0] wsamp_ff;
   logic [alm_pkg::CountWidth-1:0] offs_ff;
   logic [alm_pkg::WinWidth-1:0]   wlim_ff;
   logic                           csr_wr;
   alm_pkg::cmd_type               cmd;
   alm_pkg::sts_type               sts;
   logic [alm_pkg::LevelWidth-1:0] rsp_level;
   logic                           rsp_past;

   // Register writes
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wsamp_ff <= alm_pkg::WindowSamplesRst;
         offs_ff  <= alm_pkg::LevelOffsetRst;
         wlim_ff  <= alm_pkg::WindowLimitRst;
      end else if (csr_wr) begin
         case (csr_paddr)
            alm_pkg::AddrWindowSamples: wsamp_ff <= csr_pwdata[alm_pkg::CountWidth-1:0];
            alm_pkg::AddrLevelOffset:   offs_ff  <= csr_pwdata[alm_pkg::CountWidth-1:0];
            alm_pkg::AddrWindowLimit:   wlim_ff  <= csr_pwdata[alm_pkg::WinWidth-1:0];
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      case (csr_paddr)
         alm_pkg::AddrWindowSamples: csr_prdata = {16'b0, wsamp_ff};
         alm_pkg::AddrLevelOffset:   csr_prdata = {16'b0, offs_ff};
         alm_pkg::AddrWindowLimit:   csr_prdata = {22'b0, wlim_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   alm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   alm_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .sample         (req_tdata),
      .restart        (req_tuser[0]),
      .window_samples (wsamp_ff),
      .level_offset   (offs_ff),
      .window_limit   (wlim_ff),
      .rsp_tready     (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_level      (rsp_level),
      .rsp_past       (rsp_past)
   );

   assign rsp_tdata = {2'b0, rsp_level};
   assign rsp_tuser = rsp_past;

   // A window past the limit reports level zero
   a_past_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[5:0] == 6'd0)
      else $error("past-limit result with nonzero level");

   // Level never exceeds the table top
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[5:0] <= alm_pkg::LevelMax)
      else $error("level above maximum");

   // A new result is loaded only while the request side is held off
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result loaded while taking requests");

endmodule
